@@ hdl/slug_pkg.sv @@
package slug_pkg;

  // Park-Miller minimal standard generator constants
  localparam logic [14:0] LCG_MUL = 15'd16807;
  localparam logic [30:0] LCG_MOD = 31'h7FFF_FFFF;
  localparam int unsigned WARMUP  = 8;
  localparam logic [31:0] SEED_RESET = 32'd444;

  typedef struct packed {
    logic load_seed;   // gen word <- seed magnitude (or 1)
    logic lcg_mul;     // product <- gen word * multiplier
    logic lcg_red;     // gen word <- product mod modulus
    logic init_wr;     // table[init_idx] <- reduced value
    logic init_last;   // last_out <- reduced value
    logic slot_mul;    // slot estimate product from last_out
    logic slot_bound;  // estimate + 1 and its bound
    logic slot_read;   // corrected slot, table read issued
    logic commit;      // table write-back, last_out and result update
  } cmd_t;

  typedef struct packed {
    logic last_zero;   // table never initialized
  } sts_t;

endpackage

@@ hdl/slug_dp.sv @@
module slug_dp #(
  parameter int TABLE_SIZE = 32,
  parameter int IDX_W      = 5
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic signed [31:0]  cfg_seed,
  input  slug_pkg::cmd_t      cmd,
  input  logic [IDX_W-1:0]    init_idx,
  output slug_pkg::sts_t      sts,
  output logic [30:0]         out_draw
);
  import slug_pkg::*;

  localparam int QW = IDX_W + 1;
  localparam longint SLOT_DIV_L = (longint'(2147483646) / TABLE_SIZE) + 1;
  localparam longint RECIP_L    = (longint'(1) << 31) / SLOT_DIV_L;
  localparam logic [30:0]   SLOT_DIV = 31'(SLOT_DIV_L);
  localparam logic [QW-1:0] RECIP    = QW'(RECIP_L);
  localparam logic [QW-1:0] TS_Q     = QW'(TABLE_SIZE);
  localparam logic [QW-1:0] TS_LAST  = QW'(TABLE_SIZE - 1);

  logic signed [31:0] seed_r;
  logic [30:0]        gen_word_r, gen_word_nxt;
  logic [30:0]        last_out_r, last_out_nxt;
  logic [45:0]        prod_r;
  logic [30+QW:0]     slot_prod_r;
  logic [QW-1:0]      qe_r, qe1_r;
  logic [32:0]        bound_r;
  logic [IDX_W-1:0]   slot_r;
  logic [30:0]        rd_r;
  logic [30:0]        draw_r;
  logic [30:0]        mem [TABLE_SIZE];

  logic [31:0]        neg_seed;
  logic [31:0]        neg_red;
  logic [30:0]        seed_x;
  logic [31:0]        fold;
  logic [30:0]        red;
  logic [QW-1:0]      qe, qe1, sel;
  logic [IDX_W-1:0]   slot;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [30:0]        mem_wdata;

  // magnitude of a negative seed, reduced once by the modulus; a non-negative seed or zero gives one
  always_comb begin
    neg_seed = 32'd0 - $unsigned(seed_r);
    neg_red  = (neg_seed >= 32'(LCG_MOD)) ? (neg_seed - 32'(LCG_MOD)) : neg_seed;
    if (!seed_r[31] || (neg_red == 32'd0)) begin
      seed_x = 31'd1;
    end else begin
      seed_x = neg_red[30:0];
    end
  end

  // 2^31 == 1 (mod 2^31-1): fold high part onto low part, one correction
  always_comb begin
    fold = 32'(prod_r[45:31]) + 32'(prod_r[30:0]);
    red  = (fold >= 32'(LCG_MOD)) ? 31'(fold - 32'(LCG_MOD)) : fold[30:0];
  end

  // slot = last_out / SLOT_DIV via reciprocal estimate plus one correction, clamped to the last slot
  always_comb begin
    qe  = slot_prod_r[31 +: QW];
    qe1 = qe + QW'(1);
    sel = ({2'b00, last_out_r} >= bound_r) ? qe1_r : qe_r;
    if (sel >= TS_Q) begin
      slot = TS_LAST[IDX_W-1:0];
    end else begin
      slot = sel[IDX_W-1:0];
    end
  end

  always_comb begin
    gen_word_nxt = gen_word_r;
    if (cmd.load_seed) begin
      gen_word_nxt = seed_x;
    end else if (cmd.lcg_red) begin
      gen_word_nxt = red;
    end
  end

  always_comb begin
    last_out_nxt = last_out_r;
    if (cmd.init_last) begin
      last_out_nxt = red;
    end else if (cmd.commit) begin
      last_out_nxt = rd_r;
    end
  end

  always_comb begin
    mem_we    = cmd.init_wr || cmd.commit;
    mem_waddr = cmd.commit ? slot_r : init_idx;
    mem_wdata = cmd.commit ? gen_word_r : red;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r     <= signed'(SEED_RESET);
      gen_word_r <= '0;
      last_out_r <= '0;
    end else begin
      if (cfg_we) begin
        seed_r <= cfg_seed;
      end
      gen_word_r <= gen_word_nxt;
      last_out_r <= last_out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lcg_mul) begin
      prod_r <= 46'(gen_word_r) * 46'(LCG_MUL);
    end
    if (cmd.slot_mul) begin
      slot_prod_r <= (31 + QW)'(last_out_r) * (31 + QW)'(RECIP);
    end
    if (cmd.slot_bound) begin
      qe_r    <= qe;
      qe1_r   <= qe1;
      bound_r <= 33'(qe1) * 33'(SLOT_DIV);
    end
    if (cmd.slot_read) begin
      slot_r <= slot;
    end
    if (cmd.commit) begin
      draw_r <= rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.slot_read) begin
      rd_r <= mem[slot];
    end
  end

  assign sts.last_zero = (last_out_r == 31'd0);
  assign out_draw      = draw_r;

endmodule

@@ hdl/slug_ctrl.sv @@
module slug_ctrl #(
  parameter int TABLE_SIZE = 32,
  parameter int IDX_W      = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_restart,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  slug_pkg::sts_t     sts,
  output slug_pkg::cmd_t     cmd,
  output logic [IDX_W-1:0]   init_idx
);
  import slug_pkg::*;

  localparam int CNT_W = $clog2(TABLE_SIZE + WARMUP);
  localparam logic [CNT_W-1:0] CNT_START = CNT_W'(TABLE_SIZE + WARMUP - 1);
  localparam logic [CNT_W-1:0] CNT_TS    = CNT_W'(TABLE_SIZE);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SEED     = 3'd1;
  localparam logic [2:0] S_INIT_MUL = 3'd2;
  localparam logic [2:0] S_INIT_RED = 3'd3;
  localparam logic [2:0] S_DRAW_A   = 3'd4;
  localparam logic [2:0] S_DRAW_B   = 3'd5;
  localparam logic [2:0] S_DRAW_C   = 3'd6;
  localparam logic [2:0] S_DRAW_D   = 3'd7;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             take;

  assign take = out_valid_r && !out_stall;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = take ? 1'b0 : out_valid_r;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_restart || sts.last_zero) ? S_SEED : S_DRAW_A;
        end
      end
      S_SEED: begin
        cmd.load_seed = 1'b1;
        cnt_nxt       = CNT_START;
        state_nxt     = S_INIT_MUL;
      end
      S_INIT_MUL: begin
        cmd.lcg_mul = 1'b1;
        state_nxt   = S_INIT_RED;
      end
      S_INIT_RED: begin
        cmd.lcg_red = 1'b1;
        cmd.init_wr = (cnt_r < CNT_TS);
        if (cnt_r == '0) begin
          cmd.init_last = 1'b1;
          state_nxt     = S_DRAW_A;
        end else begin
          cnt_nxt   = cnt_r - CNT_W'(1);
          state_nxt = S_INIT_MUL;
        end
      end
      S_DRAW_A: begin
        cmd.lcg_mul  = 1'b1;
        cmd.slot_mul = 1'b1;
        state_nxt    = S_DRAW_B;
      end
      S_DRAW_B: begin
        cmd.lcg_red    = 1'b1;
        cmd.slot_bound = 1'b1;
        state_nxt      = S_DRAW_C;
      end
      S_DRAW_C: begin
        cmd.slot_read = 1'b1;
        state_nxt     = S_DRAW_D;
      end
      S_DRAW_D: begin
        // hold until the result register is free or being drained
        if (!out_valid_r || !out_stall) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign init_idx  = cnt_r[IDX_W-1:0];

endmodule

@@ hdl/shuffled_lcg_uniform_generator_core.sv @@
// Channel   Handshake             Payload
// in        in_valid / in_stall   in_restart
// out       out_valid / out_stall out_draw
// cfg       cfg_valid / cfg_ready cfg_seed
//
// A draw steps from the accept state through the generator step (multiply, fold mod
// 2^31-1) beside the reciprocal slot divide, the slot correction and registered table
// read, and the write-back. Initialization loads the seed, runs WARMUP generator steps,
// then one per table entry, the last also setting last_out. Reset clears control, gen
// word and last_out and loads seed 444; the first request then fills the table.
// A stalled result holds back the next draw's write-back, not the next input transfer.
module shuffled_lcg_uniform_generator_core #(
  parameter int TABLE_SIZE = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_restart,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [30:0]        out_draw,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic signed [31:0] cfg_seed
);
  import slug_pkg::*;

  localparam int IDX_W = $clog2(TABLE_SIZE);

  cmd_t             cmd;
  sts_t             sts;
  logic [IDX_W-1:0] init_idx;
  logic             cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  slug_ctrl #(
    .TABLE_SIZE (TABLE_SIZE),
    .IDX_W      (IDX_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_restart (in_restart),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sts        (sts),
    .cmd        (cmd),
    .init_idx   (init_idx)
  );

  slug_dp #(
    .TABLE_SIZE (TABLE_SIZE),
    .IDX_W      (IDX_W)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_seed   (cfg_seed),
    .cmd        (cmd),
    .init_idx   (init_idx),
    .sts        (sts),
    .out_draw   (out_draw)
  );

endmodule
